// ===== src/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  // Heap geometry
  localparam int HEAP_GRANULES   = 4096;
  localparam int ADDR_W          = 12;
  localparam int LEN_W           = 13;
  localparam int GRANULE_BYTES   = 16;
  localparam int GRANULE_SHIFT   = 4;
  localparam int HEADER_GRANULES = 2;
  localparam int SLACK_GRANULES  = 256;
  localparam int SLACK_SHIFT     = 8;
  localparam int SIZE_W          = 16;

  // Size-class cache
  localparam int CACHE_CLASSES = 32;
  localparam int CLS_W         = 5;
  localparam int DEPTH_W       = 5;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CACHE_DEPTH = 1'd1;

  // Request kinds
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOMEM   = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  // Boundary tag of one block
  typedef struct packed {
    logic [LEN_W-1:0]  prev_len;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] link;
    logic              busy;
  } hdr_t;

  // Header memory access: one write and one read address per cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    hdr_t              wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // One size-class cache head
  typedef struct packed {
    logic [ADDR_W-1:0]  ptr;
    logic [DEPTH_W-1:0] depth;
  } cache_ent_t;

  typedef struct packed {
    logic       we;
    cache_ent_t ent;
  } cache_wr_t;

  // Usable bytes of a block of the given granule length
  function automatic logic [SIZE_W-1:0] usable_of(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] body;
    body = len - LEN_W'(HEADER_GRANULES);
    return SIZE_W'({{(SIZE_W-LEN_W){1'b0}}, body} << GRANULE_SHIFT);
  endfunction

endpackage

// ===== src/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// Boundary-tag first-fit allocator over 16-byte granules with size caches.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready: in_action selects allocate or free,
//   in_size_bytes is the allocate size, in_block_addr the user area to free.
//   Each request yields one result on out_valid/out_ready (status, granted
//   user-area granule and usable bytes). in_ready is high only while the
//   sequencer is idle; one request is in work at a time.
//   Sequence: an allocate hit in its size cache passes S_A_CACHE, S_POP_WR
//   and S_OUT into the output register. The first-fit walk reads one block
//   header per block visited, a split rewrites the headers around it, and
//   a heap growth or cache drain is followed by a fresh walk; a drain scans
//   one size class at a time. A free walks the block chain, the class list,
//   then pushes or merges, serialized by the header memory's single read port.
//   Reset empties all size caches, sets the heap end to zero and loads the
//   configuration defaults; the header store needs no clearing.
//   A stalled result sits in the output register; the next request is
//   accepted meanwhile and its result waits until that register frees.
//   Configuration (cfg_we, cfg_index, cfg_wdata) is written by the user
//   only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_action,
  input  logic [ffha_pkg::SIZE_W-1:0]         in_size_bytes,
  input  logic [ffha_pkg::ADDR_W-1:0]         in_block_addr,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic [ffha_pkg::ADDR_W-1:0]         out_granted_addr,
  output logic [ffha_pkg::SIZE_W-1:0]         out_usable_bytes,
  input  logic                                cfg_we,
  input  logic [ffha_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ffha_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int AW = ffha_pkg::ADDR_W;
  localparam int LW = ffha_pkg::LEN_W;
  localparam int PW = ffha_pkg::LEN_W + 1;

  // sequencer states
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_A_CACHE = 5'd1;
  localparam logic [4:0] S_POP_WR  = 5'd2;
  localparam logic [4:0] S_FS_CHK  = 5'd3;
  localparam logic [4:0] S_FS_DAT  = 5'd4;
  localparam logic [4:0] S_CARVE   = 5'd5;
  localparam logic [4:0] S_CARVE_Q = 5'd6;
  localparam logic [4:0] S_CARVE_N = 5'd7;
  localparam logic [4:0] S_GR_RD   = 5'd8;
  localparam logic [4:0] S_GR_DEC  = 5'd9;
  localparam logic [4:0] S_DRAIN   = 5'd10;
  localparam logic [4:0] S_REL1    = 5'd11;
  localparam logic [4:0] S_REL2    = 5'd12;
  localparam logic [4:0] S_REL3    = 5'd13;
  localparam logic [4:0] S_REL4    = 5'd14;
  localparam logic [4:0] S_REL4B   = 5'd15;
  localparam logic [4:0] S_REL5    = 5'd16;
  localparam logic [4:0] S_REL6    = 5'd17;
  localparam logic [4:0] S_REL_END = 5'd18;
  localparam logic [4:0] S_IBS_CHK = 5'd19;
  localparam logic [4:0] S_IBS_DAT = 5'd20;
  localparam logic [4:0] S_F_HDR   = 5'd21;
  localparam logic [4:0] S_HC_INIT = 5'd22;
  localparam logic [4:0] S_HC_CHK  = 5'd23;
  localparam logic [4:0] S_HC_DAT  = 5'd24;
  localparam logic [4:0] S_PUSH    = 5'd25;
  localparam logic [4:0] S_OUT     = 5'd26;

  // what a release returns to
  localparam logic [1:0] CTX_ALLOC = 2'd0;
  localparam logic [1:0] CTX_RETRY = 2'd1;
  localparam logic [1:0] CTX_FREE  = 2'd2;

  logic [4:0]                          state_r, state_nxt;
  logic [LW-1:0]                       heap_end_r, heap_end_nxt;
  logic                                last_valid_r, last_valid_nxt;
  logic [AW-1:0]                       last_addr_r, last_addr_nxt;
  logic [LW-1:0]                       heap_limit_r;
  logic [ffha_pkg::DEPTH_W-1:0]        cache_lim_r;
  logic [PW-1:0]                       p_r, p_nxt;
  logic [LW-1:0]                       need_r, need_nxt;
  logic [AW-1:0]                       b_r, b_nxt;
  ffha_pkg::hdr_t                      h_r, h_nxt;
  logic [PW-1:0]                       nxt_r, nxt_nxt;
  logic [AW-1:0]                       prv_r, prv_nxt;
  logic [AW-1:0]                       cur_r, cur_nxt;
  logic [LW-1:0]                       cur_len_r, cur_len_nxt;
  logic [1:0]                          ctx_r, ctx_nxt;
  logic [ffha_pkg::CLS_W-1:0]          cls_r, cls_nxt;
  logic [ffha_pkg::DEPTH_W-1:0]        hc_n_r, hc_n_nxt;
  logic [1:0]                          res_status_r, res_status_nxt;
  logic [AW-1:0]                       res_addr_r, res_addr_nxt;
  logic [ffha_pkg::SIZE_W-1:0]         res_usable_r, res_usable_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [1:0]                          out_status_r, out_status_nxt;
  logic [AW-1:0]                       out_addr_r, out_addr_nxt;
  logic [ffha_pkg::SIZE_W-1:0]         out_usable_r, out_usable_nxt;

  ffha_pkg::mem_req_t                  mreq;
  ffha_pkg::hdr_t                      rd;
  ffha_pkg::cache_wr_t                 cwr;
  ffha_pkg::cache_ent_t                crd;

  // derived values
  logic [ffha_pkg::SIZE_W-1:0]         size1;
  logic [ffha_pkg::SIZE_W:0]           g_sum;
  logic [LW-1:0]                       g;
  logic [LW-1:0]                       lim;
  logic [LW-1:0]                       want;
  logic [PW-1:0]                       inc_sum;
  logic [PW-1:0]                       inc;
  logic                                grow_ok;
  logic                                live_p;
  logic [PW-1:0]                       rel_nxt;
  logic [LW-1:0]                       surplus;
  logic [PW-1:0]                       q_addr;
  logic [PW-1:0]                       end_addr;
  logic [AW-1:0]                       last_upd;
  logic [LW-1:0]                       f_cls;

  ffha_hdr_mem u_mem (
    .clk       (clk),
    .req       (mreq),
    .rd_data_r (rd)
  );

  ffha_cache u_cache (
    .clk   (clk),
    .rst_n (rst_n),
    .idx   (cls_r),
    .wr    (cwr),
    .rd    (crd)
  );

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_granted_addr = out_addr_r;
  assign out_usable_bytes = out_usable_r;

  // size rounding and growth arithmetic
  always_comb begin
    size1   = (in_size_bytes == '0) ? ffha_pkg::SIZE_W'(1) : in_size_bytes;
    g_sum   = ({1'b0, size1} + (ffha_pkg::SIZE_W+1)'(ffha_pkg::GRANULE_BYTES - 1))
              >> ffha_pkg::GRANULE_SHIFT;
    g       = g_sum[LW-1:0];
    lim     = (heap_limit_r > LW'(ffha_pkg::HEAP_GRANULES)) ?
              LW'(ffha_pkg::HEAP_GRANULES) : heap_limit_r;
    if (last_valid_r && !rd.busy) begin
      want = (rd.len >= need_r) ? '0 : need_r - rd.len;
    end else begin
      want = need_r;
    end
    inc_sum = ({1'b0, want} + PW'(ffha_pkg::SLACK_GRANULES - 1)) >> ffha_pkg::SLACK_SHIFT;
    inc     = inc_sum << ffha_pkg::SLACK_SHIFT;
    grow_ok = (inc != '0) && (inc <= {1'b0, lim}) &&
              ({1'b0, heap_end_r} <= ({1'b0, lim} - inc));
    live_p  = (p_r < {1'b0, heap_end_r}) && (p_r < PW'(ffha_pkg::HEAP_GRANULES));
    rel_nxt = {{(PW-AW){1'b0}}, b_r} + {1'b0, h_r.len};
    surplus = h_r.len - need_r;
    q_addr  = {{(PW-AW){1'b0}}, b_r} + {1'b0, need_r};
    end_addr = {{(PW-AW){1'b0}}, b_r} + {1'b0, h_r.len};
    last_upd = (last_valid_r && (last_addr_r == b_r)) ? nxt_r[AW-1:0] : last_addr_r;
    f_cls   = rd.len - LW'(ffha_pkg::HEADER_GRANULES);
  end

  // request sequencer
  always_comb begin
    state_nxt      = state_r;
    heap_end_nxt   = heap_end_r;
    last_valid_nxt = last_valid_r;
    last_addr_nxt  = last_addr_r;
    p_nxt          = p_r;
    need_nxt       = need_r;
    b_nxt          = b_r;
    h_nxt          = h_r;
    nxt_nxt        = nxt_r;
    prv_nxt        = prv_r;
    cur_nxt        = cur_r;
    cur_len_nxt    = cur_len_r;
    ctx_nxt        = ctx_r;
    cls_nxt        = cls_r;
    hc_n_nxt       = hc_n_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_usable_nxt = res_usable_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_usable_nxt = out_usable_r;
    mreq           = '0;
    cwr            = '0;

    case (state_r)
      // take a request
      S_IDLE: begin
        if (in_valid) begin
          p_nxt = '0;
          if (in_action == ffha_pkg::ACT_ALLOC) begin
            ctx_nxt  = CTX_ALLOC;
            need_nxt = g + LW'(ffha_pkg::HEADER_GRANULES);
            if (g < LW'(ffha_pkg::CACHE_CLASSES)) begin
              cls_nxt   = g[ffha_pkg::CLS_W-1:0];
              state_nxt = S_A_CACHE;
            end else begin
              state_nxt = S_FS_CHK;
            end
          end else begin
            ctx_nxt = CTX_FREE;
            if (in_block_addr < AW'(ffha_pkg::HEADER_GRANULES)) begin
              res_status_nxt = ffha_pkg::ST_IGNORED;
              res_addr_nxt   = '0;
              res_usable_nxt = '0;
              state_nxt      = S_OUT;
            end else begin
              b_nxt     = in_block_addr - AW'(ffha_pkg::HEADER_GRANULES);
              state_nxt = S_IBS_CHK;
            end
          end
        end
      end

      // size cache lookup
      S_A_CACHE: begin
        if (crd.depth != '0) begin
          mreq.raddr = crd.ptr;
          b_nxt      = crd.ptr;
          state_nxt  = S_POP_WR;
        end else begin
          state_nxt = S_FS_CHK;
        end
      end

      // pop: unlink head, clear its link
      S_POP_WR: begin
        h_nxt      = rd;
        h_nxt.link = '0;
        mreq.we    = 1'b1;
        mreq.waddr = b_r;
        mreq.wdata = h_nxt;
        cwr.we        = 1'b1;
        cwr.ent.ptr   = rd.link;
        cwr.ent.depth = crd.depth - 1'b1;
        if (ctx_r == CTX_ALLOC) begin
          res_status_nxt = ffha_pkg::ST_DONE;
          res_addr_nxt   = b_r + AW'(ffha_pkg::HEADER_GRANULES);
          res_usable_nxt = ffha_pkg::usable_of(rd.len);
          state_nxt      = S_OUT;
        end else begin
          state_nxt = S_REL1;
        end
      end

      // first-fit walk
      S_FS_CHK: begin
        if (live_p) begin
          mreq.raddr = p_r[AW-1:0];
          state_nxt  = S_FS_DAT;
        end else begin
          state_nxt = S_GR_RD;
        end
      end

      S_FS_DAT: begin
        if (rd.len == '0) begin
          state_nxt = S_GR_RD;
        end else if (!rd.busy && (rd.len >= need_r)) begin
          h_nxt     = rd;
          b_nxt     = p_r[AW-1:0];
          state_nxt = S_CARVE;
        end else begin
          p_nxt     = p_r + {1'b0, rd.len};
          state_nxt = S_FS_CHK;
        end
      end

      // mark found block used, split off a large enough surplus
      S_CARVE: begin
        mreq.we              = 1'b1;
        mreq.waddr           = b_r;
        mreq.wdata.prev_len  = h_r.prev_len;
        mreq.wdata.link      = '0;
        mreq.wdata.busy      = 1'b1;
        res_status_nxt       = ffha_pkg::ST_DONE;
        res_addr_nxt         = b_r + AW'(ffha_pkg::HEADER_GRANULES);
        if ((surplus >= LW'(ffha_pkg::HEADER_GRANULES + 1)) &&
            (q_addr < PW'(ffha_pkg::HEAP_GRANULES))) begin
          mreq.wdata.len = need_r;
          res_usable_nxt = ffha_pkg::usable_of(need_r);
          nxt_nxt        = q_addr;
          state_nxt      = S_CARVE_Q;
        end else begin
          mreq.wdata.len = h_r.len;
          res_usable_nxt = ffha_pkg::usable_of(h_r.len);
          state_nxt      = S_OUT;
        end
      end

      S_CARVE_Q: begin
        mreq.we             = 1'b1;
        mreq.waddr          = nxt_r[AW-1:0];
        mreq.wdata.prev_len = need_r;
        mreq.wdata.len      = surplus;
        mreq.wdata.link     = '0;
        mreq.wdata.busy     = 1'b0;
        last_addr_nxt       = last_upd;
        if (!(last_valid_r && (last_upd == nxt_r[AW-1:0])) &&
            (end_addr < {1'b0, heap_end_r}) &&
            (end_addr < PW'(ffha_pkg::HEAP_GRANULES))) begin
          mreq.raddr = end_addr[AW-1:0];
          nxt_nxt    = end_addr;
          state_nxt  = S_CARVE_N;
        end else begin
          state_nxt = S_OUT;
        end
      end

      S_CARVE_N: begin
        mreq.we             = 1'b1;
        mreq.waddr          = nxt_r[AW-1:0];
        mreq.wdata          = rd;
        mreq.wdata.prev_len = surplus;
        state_nxt           = S_OUT;
      end

      // heap growth: look at the last block first
      S_GR_RD: begin
        mreq.raddr = last_addr_r;
        state_nxt  = S_GR_DEC;
      end

      S_GR_DEC: begin
        if (grow_ok) begin
          mreq.we             = 1'b1;
          mreq.waddr          = heap_end_r[AW-1:0];
          mreq.wdata.prev_len = last_valid_r ? rd.len : '0;
          mreq.wdata.len      = inc[LW-1:0];
          mreq.wdata.link     = '0;
          mreq.wdata.busy     = 1'b1;
          h_nxt               = mreq.wdata;
          b_nxt               = heap_end_r[AW-1:0];
          heap_end_nxt        = heap_end_r + inc[LW-1:0];
          ctx_nxt             = CTX_RETRY;
          state_nxt           = S_REL1;
        end else begin
          cls_nxt   = ffha_pkg::CLS_W'(ffha_pkg::CACHE_CLASSES - 1);
          state_nxt = S_DRAIN;
        end
      end

      // drain the highest non-empty class back into the heap
      S_DRAIN: begin
        if (crd.depth != '0) begin
          mreq.raddr = crd.ptr;
          b_nxt      = crd.ptr;
          ctx_nxt    = CTX_RETRY;
          state_nxt  = S_POP_WR;
        end else if (cls_r == ffha_pkg::CLS_W'(1)) begin
          res_status_nxt = ffha_pkg::ST_NOMEM;
          res_addr_nxt   = '0;
          res_usable_nxt = '0;
          state_nxt      = S_OUT;
        end else begin
          cls_nxt = cls_r - 1'b1;
        end
      end

      // release: mark free, merge forward
      S_REL1: begin
        h_nxt.busy = 1'b0;
        nxt_nxt    = rel_nxt;
        prv_nxt    = (h_r.prev_len <= {1'b0, b_r}) ?
                     b_r - h_r.prev_len[AW-1:0] : b_r;
        if ((rel_nxt < {1'b0, heap_end_r}) &&
            (rel_nxt < PW'(ffha_pkg::HEAP_GRANULES))) begin
          mreq.raddr = rel_nxt[AW-1:0];
          state_nxt  = S_REL2;
        end else begin
          state_nxt = S_REL3;
        end
      end

      S_REL2: begin
        if (!rd.busy) begin
          h_nxt.len           = h_r.len + rd.len;
          mreq.we             = 1'b1;
          mreq.waddr          = nxt_r[AW-1:0];
          mreq.wdata          = rd;
          mreq.wdata.len      = '0;
          mreq.wdata.prev_len = '0;
          nxt_nxt             = {{(PW-AW){1'b0}}, b_r} + {1'b0, h_nxt.len};
        end
        state_nxt = S_REL3;
      end

      // merge backward
      S_REL3: begin
        if (prv_r != b_r) begin
          mreq.raddr = prv_r;
          state_nxt  = S_REL4;
        end else begin
          mreq.we     = 1'b1;
          mreq.waddr  = b_r;
          mreq.wdata  = h_r;
          cur_nxt     = b_r;
          cur_len_nxt = h_r.len;
          state_nxt   = S_REL5;
        end
      end

      S_REL4: begin
        mreq.we = 1'b1;
        if (!rd.busy) begin
          mreq.waddr     = prv_r;
          mreq.wdata     = rd;
          mreq.wdata.len = rd.len + h_r.len;
          cur_nxt        = prv_r;
          cur_len_nxt    = rd.len + h_r.len;
          state_nxt      = S_REL4B;
        end else begin
          mreq.waddr  = b_r;
          mreq.wdata  = h_r;
          cur_nxt     = b_r;
          cur_len_nxt = h_r.len;
          state_nxt   = S_REL5;
        end
      end

      S_REL4B: begin
        mreq.we             = 1'b1;
        mreq.waddr          = b_r;
        mreq.wdata          = h_r;
        mreq.wdata.len      = '0;
        mreq.wdata.prev_len = '0;
        state_nxt           = S_REL5;
      end

      // fix the follower or the last-block pointer
      S_REL5: begin
        if (nxt_r >= {1'b0, heap_end_r}) begin
          last_addr_nxt  = cur_r;
          last_valid_nxt = 1'b1;
          state_nxt      = S_REL_END;
        end else if (nxt_r < PW'(ffha_pkg::HEAP_GRANULES)) begin
          mreq.raddr = nxt_r[AW-1:0];
          state_nxt  = S_REL6;
        end else begin
          state_nxt = S_REL_END;
        end
      end

      S_REL6: begin
        if (rd.busy) begin
          mreq.we             = 1'b1;
          mreq.waddr          = nxt_r[AW-1:0];
          mreq.wdata          = rd;
          mreq.wdata.prev_len = cur_len_r;
        end
        state_nxt = S_REL_END;
      end

      S_REL_END: begin
        if (ctx_r == CTX_FREE) begin
          res_status_nxt = ffha_pkg::ST_DONE;
          res_addr_nxt   = '0;
          res_usable_nxt = '0;
          state_nxt      = S_OUT;
        end else begin
          p_nxt     = '0;
          state_nxt = S_FS_CHK;
        end
      end

      // free: check the address is a block start
      S_IBS_CHK: begin
        if (live_p && (p_r <= {{(PW-AW){1'b0}}, b_r})) begin
          if (p_r[AW-1:0] == b_r) begin
            mreq.raddr = b_r;
            state_nxt  = S_F_HDR;
          end else begin
            mreq.raddr = p_r[AW-1:0];
            state_nxt  = S_IBS_DAT;
          end
        end else begin
          res_status_nxt = ffha_pkg::ST_IGNORED;
          res_addr_nxt   = '0;
          res_usable_nxt = '0;
          state_nxt      = S_OUT;
        end
      end

      S_IBS_DAT: begin
        if (rd.len == '0) begin
          res_status_nxt = ffha_pkg::ST_IGNORED;
          res_addr_nxt   = '0;
          res_usable_nxt = '0;
          state_nxt      = S_OUT;
        end else begin
          p_nxt     = p_r + {1'b0, rd.len};
          state_nxt = S_IBS_CHK;
        end
      end

      S_F_HDR: begin
        h_nxt = rd;
        if (!rd.busy) begin
          res_status_nxt = ffha_pkg::ST_IGNORED;
          res_addr_nxt   = '0;
          res_usable_nxt = '0;
          state_nxt      = S_OUT;
        end else if ((rd.len >= LW'(ffha_pkg::HEADER_GRANULES)) &&
                     (f_cls < LW'(ffha_pkg::CACHE_CLASSES))) begin
          cls_nxt   = f_cls[ffha_pkg::CLS_W-1:0];
          state_nxt = S_HC_INIT;
        end else begin
          state_nxt = S_REL1;
        end
      end

      // free: reject a block already on its class list
      S_HC_INIT: begin
        p_nxt     = {{(PW-AW){1'b0}}, crd.ptr};
        hc_n_nxt  = crd.depth;
        state_nxt = S_HC_CHK;
      end

      S_HC_CHK: begin
        if (hc_n_r != '0) begin
          if (p_r[AW-1:0] == b_r) begin
            res_status_nxt = ffha_pkg::ST_IGNORED;
            res_addr_nxt   = '0;
            res_usable_nxt = '0;
            state_nxt      = S_OUT;
          end else begin
            mreq.raddr = p_r[AW-1:0];
            state_nxt  = S_HC_DAT;
          end
        end else begin
          state_nxt = S_PUSH;
        end
      end

      S_HC_DAT: begin
        p_nxt     = {{(PW-AW){1'b0}}, rd.link};
        hc_n_nxt  = hc_n_r - 1'b1;
        state_nxt = S_HC_CHK;
      end

      // free: push on class list or release into the heap
      S_PUSH: begin
        if (crd.depth < cache_lim_r) begin
          mreq.we         = 1'b1;
          mreq.waddr      = b_r;
          mreq.wdata      = h_r;
          mreq.wdata.link = crd.ptr;
          cwr.we          = 1'b1;
          cwr.ent.ptr     = b_r;
          cwr.ent.depth   = crd.depth + 1'b1;
          res_status_nxt  = ffha_pkg::ST_DONE;
          res_addr_nxt    = '0;
          res_usable_nxt  = '0;
          state_nxt       = S_OUT;
        end else begin
          state_nxt = S_REL1;
        end
      end

      // hand the result to the output register
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          out_usable_nxt = res_usable_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      heap_end_r   <= '0;
      last_valid_r <= 1'b0;
      last_addr_r  <= '0;
      heap_limit_r <= LW'(ffha_pkg::HEAP_GRANULES);
      cache_lim_r  <= ffha_pkg::DEPTH_W'(16);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      heap_end_r   <= heap_end_nxt;
      last_valid_r <= last_valid_nxt;
      last_addr_r  <= last_addr_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          ffha_pkg::CFG_HEAP_LIMIT:  heap_limit_r <= cfg_wdata[LW-1:0];
          ffha_pkg::CFG_CACHE_DEPTH: cache_lim_r  <= cfg_wdata[ffha_pkg::DEPTH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    p_r          <= p_nxt;
    need_r       <= need_nxt;
    b_r          <= b_nxt;
    h_r          <= h_nxt;
    nxt_r        <= nxt_nxt;
    prv_r        <= prv_nxt;
    cur_r        <= cur_nxt;
    cur_len_r    <= cur_len_nxt;
    ctx_r        <= ctx_nxt;
    cls_r        <= cls_nxt;
    hc_n_r       <= hc_n_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_usable_r <= res_usable_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_usable_r <= out_usable_nxt;
  end

endmodule

// ===== src/ffha_hdr_mem.sv =====
// ----------------------------------------------------------------------------
// ffha_hdr_mem
// Boundary-tag store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffha_hdr_mem (
  input  logic               clk,
  input  ffha_pkg::mem_req_t req,
  output ffha_pkg::hdr_t     rd_data_r
);

  ffha_pkg::hdr_t mem_q [ffha_pkg::HEAP_GRANULES];

  // write, and read with write-through forwarding on address match
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_q[req.waddr] <= req.wdata;
    end
    if (req.we && (req.waddr == req.raddr)) begin
      rd_data_r <= req.wdata;
    end else begin
      rd_data_r <= mem_q[req.raddr];
    end
  end

endmodule

// ===== src/ffha_cache.sv =====
// ----------------------------------------------------------------------------
// ffha_cache
// Size-class cache heads: list head and depth per class, empty at reset.
// ----------------------------------------------------------------------------
module ffha_cache (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [ffha_pkg::CLS_W-1:0]         idx,
  input  ffha_pkg::cache_wr_t                wr,
  output ffha_pkg::cache_ent_t               rd
);

  ffha_pkg::cache_ent_t ent_r [ffha_pkg::CACHE_CLASSES];

  // one entry updated per cycle at the selected class
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ffha_pkg::CACHE_CLASSES; i++) begin
        ent_r[i] <= '0;
      end
    end else if (wr.we) begin
      ent_r[idx] <= wr.ent;
    end
  end

  assign rd = ent_r[idx];

endmodule

// ===== src/ffha_checker.sv =====
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffha_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_status,
  input logic [ffha_pkg::ADDR_W-1:0] out_granted_addr,
  input logic [ffha_pkg::SIZE_W-1:0] out_usable_bytes
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_granted_addr) && $stable(out_usable_bytes))
    else $error("result changed while stalled");

  // only defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ffha_pkg::ST_DONE) || (out_status == ffha_pkg::ST_NOMEM) ||
      (out_status == ffha_pkg::ST_IGNORED))
    else $error("undefined status code");

  // failed requests carry no grant
  a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ffha_pkg::ST_DONE) |->
      (out_granted_addr == '0) && (out_usable_bytes == '0))
    else $error("grant on failed request");

  // reset empties the output
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_granted_addr (out_granted_addr),
  .out_usable_bytes (out_usable_bytes)
);
